/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
// Plain text only, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, live during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/cmr_pkg.sv */
// Package for the common median reference block: sizes, types, codes.
// No dependencies.
package cmr_pkg;

   localparam int CHANNELS   = 16;
   localparam int CH_W       = 4;
   localparam int SAMPLE_W   = 16;
   localparam int REFD_W     = 17;
   localparam int MODE_W     = 2;
   localparam int STEP_W     = $clog2(CHANNELS + 1);
   localparam int MID_LO     = CHANNELS / 2 - 1;
   localparam int MID_HI     = CHANNELS / 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [REFD_W-1:0]   refd_type;
   typedef logic [CH_W-1:0]            chan_type;
   typedef logic [MODE_W-1:0]          mode_type;

   localparam mode_type MODE_PASS = 2'd0;

   // register index in the address word bit
   localparam logic REG_MODE_IDX = 1'b0;

   typedef struct packed {
      logic start;
   } med_ctl_type;

   typedef struct packed {
      logic done;
   } med_sts_type;

endpackage

/* hw/rtl/cmr_if.sv */
// Valid/ready channel interfaces for sample words and result words.
// Depends on cmr_pkg.
interface cmr_req_if;
   logic               valid;
   logic               ready;
   cmr_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface cmr_rsp_if;
   logic              valid;
   logic              ready;
   cmr_pkg::refd_type referenced_sample;
   cmr_pkg::chan_type channel_index;
   logic              frame_last;

   modport source (output valid, output referenced_sample, output channel_index,
                   output frame_last, input ready);
   modport sink   (input valid, input referenced_sample, input channel_index,
                   input frame_last, output ready);
endinterface

/* hw/rtl/cmr_store.sv */
// Frame store: one write port, two registered read ports.
// Depends on cmr_pkg.
module cmr_store (
   input  logic                clock,
   input  logic                wr_en,
   input  cmr_pkg::chan_type   wr_addr,
   input  cmr_pkg::sample_type wr_data,
   input  cmr_pkg::chan_type   rd_a_addr,
   output cmr_pkg::sample_type rd_a_data,
   input  cmr_pkg::chan_type   rd_b_addr,
   output cmr_pkg::sample_type rd_b_data
);
   import cmr_pkg::*;

   sample_type mem [CHANNELS];
   sample_type rd_a_ff;
   sample_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* hw/rtl/cmr_median.sv */
// Median finder: ranks each stored sample with one shared comparator and
// keeps the two middle ranks. Depends on cmr_pkg.
module cmr_median (
   input  logic                clock,
   input  logic                reset,
   input  cmr_pkg::med_ctl_type ctl,
   output cmr_pkg::med_sts_type sts,
   output cmr_pkg::chan_type   rd_a_addr,
   input  cmr_pkg::sample_type rd_a_data,
   output cmr_pkg::chan_type   rd_b_addr,
   input  cmr_pkg::sample_type rd_b_data,
   output cmr_pkg::sample_type median
);
   import cmr_pkg::*;

   typedef enum logic [1:0] {
      M_IDLE = 2'b01,
      M_SCAN = 2'b10
   } med_state_type;

   med_state_type           state_ff, state_in;
   chan_type                cand_ff, cand_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   chan_type                count_ff, count_in;
   logic                    done_ff, done_in;
   sample_type              lo_ff, hi_ff;
   chan_type                jd;
   chan_type                rank;
   logic                    less;
   logic                    step_end;
   logic signed [SAMPLE_W:0] sum;

   assign rd_a_addr = cand_ff;
   assign rd_b_addr = step_ff[CH_W-1:0];

   // registered read data belongs to the previous step's address
   assign jd   = step_ff[CH_W-1:0] - CH_W'(1);
   // ties broken by channel so ranks form a permutation
   assign less = (rd_b_data < rd_a_data) || ((rd_b_data == rd_a_data) && (jd < cand_ff));
   assign rank = count_ff + CH_W'(less);
   assign step_end = (step_ff == STEP_W'(CHANNELS));

   always_comb begin
      state_in = state_ff;
      cand_in  = cand_ff;
      step_in  = step_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (ctl.start) begin
               state_in = M_SCAN;
               cand_in  = '0;
               step_in  = '0;
            end
         end
         M_SCAN: begin
            if (step_ff == '0) begin
               count_in = '0;
            end else if (!step_end) begin
               count_in = rank;
            end
            if (step_end) begin
               step_in = '0;
               if (cand_ff == CH_W'(CHANNELS - 1)) begin
                  state_in = M_IDLE;
                  done_in  = 1'b1;
               end else begin
                  cand_in = cand_ff + CH_W'(1);
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         cand_ff  <= '0;
         step_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cand_ff  <= cand_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == M_SCAN && step_end) begin
         if (rank == CH_W'(MID_LO)) begin
            lo_ff <= rd_a_data;
         end
         if (rank == CH_W'(MID_HI)) begin
            hi_ff <= rd_a_data;
         end
      end
   end

   // floor of the mean: arithmetic shift of the 17-bit sum
   assign sum    = {lo_ff[SAMPLE_W-1], lo_ff} + {hi_ff[SAMPLE_W-1], hi_ff};
   assign median = sum[SAMPLE_W:1];
   assign sts.done = done_ff;

endmodule

/* hw/rtl/common_median_reference_16ch_top.sv */
// Common median reference, 16 channels. Sample words arrive one channel at
// a time in channel order and go into a 16-entry store; the word of channel
// 15 closes the frame. With reref_mode nonzero the block then finds the
// frame median (floor of the mean of the 8th and 9th smallest samples) by
// ranking every sample against all others with one shared comparator,
// one candidate at a time. It then emits 16 result words, sample minus
// median, in channel order, frame_last on channel 15; each word takes a
// store read and then an output load. With reref_mode 0 the ranking pass
// is skipped. req.ready is high only while the frame is loading. The
// output register lets the block go back to loading while the last result
// still waits. reref_mode is taken when the frame closes. CSR: one
// register at byte address 0 (paddr bit 2 selects it), pready always high,
// reads return it.
module common_median_reference_16ch_top (
   input  logic                                clock,
   input  logic                                reset,
   cmr_req_if.sink                             req,
   cmr_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cmr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cmr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cmr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import cmr_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD = 3'b001,
      S_RANK = 3'b010,
      S_EMIT = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   mode_type      mode_ff;
   chan_type      loaded_ff, loaded_in;
   chan_type      emit_idx_ff, emit_idx_in;
   logic          data_ok_ff, data_ok_in;
   sample_type    median_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   refd_type      refd_ff;
   chan_type      chan_ff;
   logic          last_ff;

   logic          req_acc;
   logic          frame_full;
   logic          out_load;
   logic          emit_last;
   logic          csr_wr;

   med_ctl_type   med_ctl;
   med_sts_type   med_sts;
   chan_type      med_a_addr, med_b_addr, rd_b_addr;
   sample_type    rd_a_data, rd_b_data, med_value;

   // ---- CSR ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_MODE_IDX);
   assign csr_prdata = (csr_paddr[2] == REG_MODE_IDX) ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_wr) begin
         mode_ff <= csr_pwdata[MODE_W-1:0];
      end
   end

   // ---- load side ----
   assign req.ready  = (state_ff == S_LOAD);
   assign req_acc    = req.valid && req.ready;
   assign frame_full = req_acc && (loaded_ff == CH_W'(CHANNELS - 1));
   assign med_ctl.start = frame_full && (mode_ff != MODE_PASS);

   // ---- emit side ----
   // data_ok: store read data matches emit_idx (set in the cycle after emit_idx moved)
   assign out_load  = (state_ff == S_EMIT) && data_ok_ff && (!rsp_valid_ff || rsp.ready);
   assign emit_last = (emit_idx_ff == CH_W'(CHANNELS - 1));
   assign rd_b_addr = (state_ff == S_EMIT) ? emit_idx_ff : med_b_addr;

   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      emit_idx_in = emit_idx_ff;
      data_ok_in  = 1'b0;
      if (req_acc) begin
         loaded_in = frame_full ? '0 : loaded_ff + CH_W'(1);
      end
      unique case (state_ff)
         S_LOAD: begin
            if (frame_full) begin
               state_in    = (mode_ff != MODE_PASS) ? S_RANK : S_EMIT;
               emit_idx_in = '0;
            end
         end
         S_RANK: begin
            if (med_sts.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            data_ok_in = !out_load;
            if (out_load) begin
               if (emit_last) begin
                  state_in = S_LOAD;
               end else begin
                  emit_idx_in = emit_idx_ff + CH_W'(1);
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         emit_idx_ff  <= '0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         emit_idx_ff  <= emit_idx_in;
         data_ok_ff   <= data_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (frame_full && (mode_ff == MODE_PASS)) begin
         median_ff <= '0;
      end else if ((state_ff == S_RANK) && med_sts.done) begin
         median_ff <= med_value;
      end
      if (out_load) begin
         refd_ff <= {rd_b_data[SAMPLE_W-1], rd_b_data} -
                    {median_ff[SAMPLE_W-1], median_ff};
         chan_ff <= emit_idx_ff;
         last_ff <= emit_last;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.referenced_sample = refd_ff;
   assign rsp.channel_index     = chan_ff;
   assign rsp.frame_last        = last_ff;

   cmr_store u_store (
      .clock     (clock),
      .wr_en     (req_acc),
      .wr_addr   (loaded_ff),
      .wr_data   (req.sample),
      .rd_a_addr (med_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   cmr_median u_median (
      .clock     (clock),
      .reset     (reset),
      .ctl       (med_ctl),
      .sts       (med_sts),
      .rd_a_addr (med_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (med_b_addr),
      .rd_b_data (rd_b_data),
      .median    (med_value)
   );

endmodule

/* hw/rtl/cmr_checker.sv */
// Port-level checks for the common median reference top, with its bind.
// Depends on cmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cmr_pkg::refd_type rsp_referenced_sample,
   input cmr_pkg::chan_type rsp_channel_index,
   input logic              rsp_frame_last
);
   import cmr_pkg::*;

   localparam chan_type LAST_CH = CH_W'(CHANNELS - 1);

   // whole result payload, for the hold check
   logic [REFD_W+CH_W:0] rsp_word;

   assign rsp_word = {rsp_referenced_sample, rsp_channel_index, rsp_frame_last};

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // frame_last only on the top channel
   `ASSERT_SAME(a_last_chan, clock, reset, rsp_valid && rsp_frame_last, rsp_channel_index == LAST_CH)

   // mid-frame results pending means the loader is closed
   `ASSERT_SAME(a_no_load_mid_emit, clock, reset, rsp_valid && !rsp_frame_last, !req_ready)

   // a result never appears the cycle after a sample word
   `ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid)

   // reset empties the output register
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

endmodule

bind common_median_reference_16ch_top cmr_checker u_cmr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req.valid),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_referenced_sample (rsp.referenced_sample),
   .rsp_channel_index     (rsp.channel_index),
   .rsp_frame_last        (rsp.frame_last)
);
